// ----- rtl/core/lfu_page_replacement_assert.svh -----
// Assertion macros shared by the page replacement RTL
`ifndef LFU_PAGE_REPLACEMENT_ASSERT_SVH
`define LFU_PAGE_REPLACEMENT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LFU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LFU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/lfu_pkg.sv -----
// Shared types and fixed constants for the page replacement block
`timescale 1ns / 1ps

package lfu_pkg;

    // fixed port widths
    localparam int CFG_W      = 5;
    localparam int PAGE_ID_W  = 20;
    localparam int SLOT_OUT_W = 4;
    localparam int FAULT_W    = 32;

    // frame limit after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // commands from controller to datapath
    typedef struct packed {
        logic load;     // latch the page, restart the scan
        logic scan;     // issue one frame read
        logic update;   // commit the replacement decision
    } lfu_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic scan_last;    // the read being issued is the last frame
    } lfu_sts_t;

endpackage

// ----- rtl/core/lfu_ctrl.sv -----
// Sequencer: accept, frame scan, decision and result strobe
`timescale 1ns / 1ps

module lfu_ctrl
    import lfu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output logic     done,
    output lfu_cmd_t cmd,
    input  lfu_sts_t sts
);

`include "lfu_page_replacement_assert.svh"

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_LAST   = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       done_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_UPDATE);
        end
    end

    // commands
    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign cmd.load   = (state_reg == ST_IDLE) && start;
    assign cmd.scan   = (state_reg == ST_SCAN);
    assign cmd.update = (state_reg == ST_UPDATE);

    `LFU_ASSERT_NOW(a_idle_quiet, !busy, !cmd.scan && !cmd.update, "datapath commanded while idle")
    `LFU_ASSERT_NEXT(a_update_strobe, cmd.update, done && !busy, "result strobe missing after update")

endmodule

// ----- rtl/core/lfu_dpath.sv -----
// Frame store, scan compare, victim selection and result registers
`timescale 1ns / 1ps

module lfu_dpath
    import lfu_pkg::*;
#(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 20,
    parameter int USE_BITS  = 16,
    parameter int TIME_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lfu_cmd_t              cmd,
    output lfu_sts_t              sts,
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic [PAGE_ID_W-1:0]  page_id,
    output logic                  hit,
    output logic [SLOT_OUT_W-1:0] frame_slot,
    output logic                  victim_valid,
    output logic [PAGE_ID_W-1:0]  victim_page,
    output logic [FAULT_W-1:0]    fault_total
);

`include "lfu_page_replacement_assert.svh"

    localparam int SLOT_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W   = $clog2(FRAMES + 1);
    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int PG_W    = (PAGE_BITS > PAGE_ID_W) ? PAGE_BITS : PAGE_ID_W;
    localparam int SO_W    = (SLOT_W > SLOT_OUT_W) ? SLOT_W : SLOT_OUT_W;
    localparam int ENTRY_W = PAGE_BITS + USE_BITS + TIME_BITS;

    // frame store: {page, uses, last reference}
    logic [ENTRY_W-1:0]   mem [FRAMES];
    logic [ENTRY_W-1:0]   rd_data_reg;
    logic [FRAMES-1:0]    slot_valid_reg;

    logic [CFG_W-1:0]     frames_in_use_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [SLOT_W-1:0]    scan_ptr_reg;
    logic                 cmp_valid_reg;
    logic [SLOT_W-1:0]    cmp_idx_reg;
    logic [TIME_BITS-1:0] ref_clock_reg;
    logic [CNT_W-1:0]     resident_total_reg;
    logic [FAULT_W-1:0]   faults_seen_reg;

    // scan accumulators
    logic                 hit_found_reg;
    logic [SLOT_W-1:0]    hit_idx_reg;
    logic [USE_BITS-1:0]  hit_uses_reg;
    logic                 empty_found_reg;
    logic [SLOT_W-1:0]    empty_idx_reg;
    logic                 best_found_reg;
    logic [SLOT_W-1:0]    best_idx_reg;
    logic [USE_BITS-1:0]  best_uses_reg;
    logic [TIME_BITS-1:0] best_age_reg;
    logic [PAGE_BITS-1:0] best_page_reg;

    // result registers
    logic                 hit_out_reg;
    logic [SLOT_W-1:0]    slot_out_reg;
    logic                 victim_valid_reg;
    logic [PAGE_BITS-1:0] victim_page_reg;

    logic [PG_W-1:0]      page_in_ext;
    logic [PG_W-1:0]      victim_ext;
    logic [SO_W-1:0]      slot_ext;

    logic [PAGE_BITS-1:0] e_page;
    logic [USE_BITS-1:0]  e_uses;
    logic [TIME_BITS-1:0] e_last;
    logic [TIME_BITS-1:0] e_age;
    logic                 e_valid;
    logic                 take_hit;
    logic                 take_empty;
    logic                 take_best;

    logic [CMP_W-1:0]     limit;
    logic                 has_room;
    logic                 evict;
    logic [SLOT_W-1:0]    tgt_slot;
    logic [USE_BITS-1:0]  tgt_uses;
    logic [ENTRY_W-1:0]   wr_data;

    assign page_in_ext   = PG_W'(page_id);
    assign sts.scan_last = (scan_ptr_reg == SLOT_W'(FRAMES - 1));

    // unpack the entry under compare
    assign e_page  = rd_data_reg[ENTRY_W-1 -: PAGE_BITS];
    assign e_uses  = rd_data_reg[TIME_BITS +: USE_BITS];
    assign e_last  = rd_data_reg[TIME_BITS-1:0];
    assign e_age   = ref_clock_reg - e_last;
    assign e_valid = slot_valid_reg[cmp_idx_reg];

    // per-frame compare; strict tests keep the lowest frame on full ties
    always_comb
    begin
        take_hit   = cmp_valid_reg && e_valid && !hit_found_reg && (e_page == page_reg);
        take_empty = cmp_valid_reg && !e_valid && !empty_found_reg;
        take_best  = cmp_valid_reg && e_valid &&
                     (!best_found_reg || (e_uses < best_uses_reg) ||
                      ((e_uses == best_uses_reg) && (e_age > best_age_reg)));
    end

    // effective frame limit: zero acts as one, clipped to FRAMES
    always_comb
    begin
        limit = CMP_W'(frames_in_use_reg);
        if (limit == '0)
        begin
            limit = CMP_W'(1);
        end
        if (limit > CMP_W'(FRAMES))
        begin
            limit = CMP_W'(FRAMES);
        end
    end

    // replacement decision
    always_comb
    begin
        has_room = (CMP_W'(resident_total_reg) < limit);
        evict    = !hit_found_reg && !has_room;
        priority if (hit_found_reg)
        begin
            tgt_slot = hit_idx_reg;
            tgt_uses = (hit_uses_reg == {USE_BITS{1'b1}}) ? hit_uses_reg
                                                         : hit_uses_reg + 1'b1;
        end
        else if (has_room)
        begin
            tgt_slot = empty_idx_reg;
            tgt_uses = USE_BITS'(1);
        end
        else
        begin
            tgt_slot = best_idx_reg;
            tgt_uses = USE_BITS'(1);
        end
        wr_data = {page_reg, tgt_uses, ref_clock_reg};
    end

    // frame store access
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            mem[tgt_slot] <= wr_data;
        end
        if (cmd.scan)
        begin
            rd_data_reg <= mem[scan_ptr_reg];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg  <= CFG_RESET;
            slot_valid_reg     <= '0;
            ref_clock_reg      <= '0;
            resident_total_reg <= '0;
            faults_seen_reg    <= '0;
            cmp_valid_reg      <= 1'b0;
            hit_found_reg      <= 1'b0;
            empty_found_reg    <= 1'b0;
            best_found_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                frames_in_use_reg <= cfg_data;
            end
            cmp_valid_reg <= cmd.scan;
            if (cmd.load)
            begin
                hit_found_reg   <= 1'b0;
                empty_found_reg <= 1'b0;
                best_found_reg  <= 1'b0;
            end
            else
            begin
                if (take_hit)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (take_empty)
                begin
                    empty_found_reg <= 1'b1;
                end
                if (take_best)
                begin
                    best_found_reg <= 1'b1;
                end
            end
            if (cmd.update)
            begin
                ref_clock_reg <= ref_clock_reg + 1'b1;
                if (!hit_found_reg)
                begin
                    if (faults_seen_reg != {FAULT_W{1'b1}})
                    begin
                        faults_seen_reg <= faults_seen_reg + 1'b1;
                    end
                    if (has_room)
                    begin
                        slot_valid_reg[tgt_slot] <= 1'b1;
                        resident_total_reg       <= resident_total_reg + 1'b1;
                    end
                end
            end
        end
    end

    // payload: page latch, scan pointer, accumulators, results
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg     <= page_in_ext[PAGE_BITS-1:0];
            scan_ptr_reg <= '0;
        end
        else if (cmd.scan)
        begin
            scan_ptr_reg <= scan_ptr_reg + 1'b1;
        end
        cmp_idx_reg <= scan_ptr_reg;
        if (take_hit)
        begin
            hit_idx_reg  <= cmp_idx_reg;
            hit_uses_reg <= e_uses;
        end
        if (take_empty)
        begin
            empty_idx_reg <= cmp_idx_reg;
        end
        if (take_best)
        begin
            best_idx_reg  <= cmp_idx_reg;
            best_uses_reg <= e_uses;
            best_age_reg  <= e_age;
            best_page_reg <= e_page;
        end
        if (cmd.update)
        begin
            hit_out_reg      <= hit_found_reg;
            slot_out_reg     <= tgt_slot;
            victim_valid_reg <= evict;
            victim_page_reg  <= evict ? best_page_reg : '0;
        end
    end

    // outputs
    assign victim_ext   = PG_W'(victim_page_reg);
    assign slot_ext     = SO_W'(slot_out_reg);
    assign hit          = hit_out_reg;
    assign frame_slot   = slot_ext[SLOT_OUT_W-1:0];
    assign victim_valid = victim_valid_reg;
    assign victim_page  = victim_ext[PAGE_ID_W-1:0];
    assign fault_total  = faults_seen_reg;

    `LFU_ASSERT_NOW(a_resident_count, 1'b1, $countones(slot_valid_reg) == resident_total_reg, "resident count out of step with valid bits")
    `LFU_ASSERT_NOW(a_fill_has_empty, cmd.update && !hit_found_reg && has_room, empty_found_reg, "fill without an empty frame")
    `LFU_ASSERT_NOW(a_evict_has_best, cmd.update && evict, best_found_reg, "eviction without a resident candidate")

endmodule

// ----- rtl/core/lfu_page_replacement.sv -----
// Top level: LFU page replacement with least-recently-referenced tie break
// Sequence: frame reads from a single-port store cover every frame, the last read
//   is compared, the decision is committed, and done then rises from its register;
//   a new reference is taken only once the block is back in idle.
// Reset: no pages resident, fault total and reference clock zero, limit 16.
// Results are held for one cycle under done; the receiver cannot stall.
`timescale 1ns / 1ps

module lfu_page_replacement
    import lfu_pkg::*;
#(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 20,
    parameter int USE_BITS  = 16,
    parameter int TIME_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [PAGE_ID_W-1:0]  page_id,
    output logic                  done,
    output logic                  hit,
    output logic [SLOT_OUT_W-1:0] frame_slot,
    output logic                  victim_valid,
    output logic [PAGE_ID_W-1:0]  victim_page,
    output logic [FAULT_W-1:0]    fault_total,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_data
);

    lfu_cmd_t cmd;
    lfu_sts_t sts;

    // configuration beats are always taken
    assign cfg_ready = 1'b1;

    lfu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    lfu_dpath #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .USE_BITS  (USE_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .page_id      (page_id),
        .hit          (hit),
        .frame_slot   (frame_slot),
        .victim_valid (victim_valid),
        .victim_page  (victim_page),
        .fault_total  (fault_total)
    );

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for lfu_page_replacement: directed table, then random references
`timescale 1ns / 1ps

module tb_top
    import lfu_pkg::*;
();

    localparam int FRAMES      = 16;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 40;

    // one result beat
    typedef struct {
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  vic_valid;
        logic [PAGE_ID_W-1:0]  vic_page;
        logic [FAULT_W-1:0]    faults;
    } ref_result_t;

    typedef enum logic {ROW_REF, ROW_CFG} row_kind_t;

    // directed row: a limit write or one reference, optionally with a hand-typed result
    typedef struct {
        row_kind_t            kind;
        logic [PAGE_ID_W-1:0] value;
        bit                   typed;
        ref_result_t          want;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [PAGE_ID_W-1:0]  page_id;
    logic                  done;
    logic                  hit;
    logic [SLOT_OUT_W-1:0] frame_slot;
    logic                  victim_valid;
    logic [PAGE_ID_W-1:0]  victim_page;
    logic [FAULT_W-1:0]    fault_total;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data;

    // predictor state
    logic [CFG_W-1:0]     limit_reg = CFG_RESET;
    logic                 frame_valid [FRAMES];
    logic [PAGE_ID_W-1:0] frame_page  [FRAMES];
    logic [15:0]          frame_uses  [FRAMES];
    logic [31:0]          frame_stamp [FRAMES];
    logic [31:0]          ref_tick    = '0;
    int                   resident_cnt = 0;
    logic [FAULT_W-1:0]   fault_cnt   = '0;

    ref_result_t pending_results [$];
    int          mismatches   = 0;
    int          stall_cycles = 0;

    // limit zero acts as one; it is cut, raised, cut again, raised, then pushed past 16
    dir_row_t dir_rows [23] = '{
        '{ROW_CFG, 20'h00000, 1'b0, '{1'b0, 4'd0, 1'b0, 20'h00000, 32'd0}},
        '{ROW_REF, 20'h00000, 1'b1, '{1'b0, 4'd0, 1'b0, 20'h00000, 32'd1}},
        '{ROW_REF, 20'h00000, 1'b1, '{1'b1, 4'd0, 1'b0, 20'h00000, 32'd1}},
        '{ROW_REF, 20'hFFFFF, 1'b1, '{1'b0, 4'd0, 1'b1, 20'h00000, 32'd2}},
        '{ROW_REF, 20'hAAAAA, 1'b1, '{1'b0, 4'd0, 1'b1, 20'hFFFFF, 32'd3}},
        '{ROW_CFG, 20'h00002, 1'b0, '{1'b0, 4'd0, 1'b0, 20'h00000, 32'd0}},
        '{ROW_REF, 20'h55555, 1'b1, '{1'b0, 4'd1, 1'b0, 20'h00000, 32'd4}},
        '{ROW_REF, 20'h55555, 1'b1, '{1'b1, 4'd1, 1'b0, 20'h00000, 32'd4}},
        '{ROW_REF, 20'h00F0F, 1'b1, '{1'b0, 4'd0, 1'b1, 20'hAAAAA, 32'd5}},
        // lowered below the resident count: misses keep evicting
        '{ROW_CFG, 20'h00001, 1'b0, '{1'b0, 4'd0, 1'b0, 20'h00000, 32'd0}},
        '{ROW_REF, 20'h0F0F0, 1'b1, '{1'b0, 4'd0, 1'b1, 20'h00F0F, 32'd6}},
        '{ROW_CFG, 20'h00003, 1'b0, '{1'b0, 4'd0, 1'b0, 20'h00000, 32'd0}},
        '{ROW_REF, 20'h33333, 1'b1, '{1'b0, 4'd2, 1'b0, 20'h00000, 32'd7}},
        // equal counts: the older reference goes
        '{ROW_REF, 20'h44444, 1'b1, '{1'b0, 4'd0, 1'b1, 20'h0F0F0, 32'd8}},
        '{ROW_REF, 20'h66666, 1'b1, '{1'b0, 4'd2, 1'b1, 20'h33333, 32'd9}},
        // limit above the frame count acts as 16
        '{ROW_CFG, 20'h0001F, 1'b0, '{1'b0, 4'd0, 1'b0, 20'h00000, 32'd0}},
        '{ROW_REF, 20'h66666, 1'b0, '{1'b0, 4'd0, 1'b0, 20'h00000, 32'd0}},
        '{ROW_REF, 20'h00001, 1'b0, '{1'b0, 4'd0, 1'b0, 20'h00000, 32'd0}},
        '{ROW_REF, 20'h80000, 1'b0, '{1'b0, 4'd0, 1'b0, 20'h00000, 32'd0}},
        '{ROW_REF, 20'h7FFFF, 1'b0, '{1'b0, 4'd0, 1'b0, 20'h00000, 32'd0}},
        '{ROW_REF, 20'h44444, 1'b0, '{1'b0, 4'd0, 1'b0, 20'h00000, 32'd0}},
        '{ROW_REF, 20'hFFFFF, 1'b0, '{1'b0, 4'd0, 1'b0, 20'h00000, 32'd0}},
        '{ROW_REF, 20'h00000, 1'b0, '{1'b0, 4'd0, 1'b0, 20'h00000, 32'd0}}
    };

    lfu_page_replacement dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .page_id      (page_id),
        .done         (done),
        .hit          (hit),
        .frame_slot   (frame_slot),
        .victim_valid (victim_valid),
        .victim_page  (victim_page),
        .fault_total  (fault_total),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    // LFU lookup and replacement for one reference; updates the predictor state
    function automatic ref_result_t lfu_predict(input logic [PAGE_ID_W-1:0] page);
        ref_result_t r;
        int          lim;
        int          slot;
        int          best_uses;
        logic [31:0] best_age;
        logic [31:0] age;
        bit          found;
        r = '{1'b0, '0, 1'b0, '0, '0};
        slot = 0;
        for (int k = 0; k < FRAMES; k++)
        begin
            if (!r.hit && frame_valid[k] && frame_page[k] == page)
            begin
                r.hit = 1'b1;
                slot = k;
            end
        end
        if (r.hit)
        begin
            if (frame_uses[slot] != 16'hFFFF)
                frame_uses[slot] = frame_uses[slot] + 16'd1;
            frame_stamp[slot] = ref_tick;
        end
        else
        begin
            if (fault_cnt != '1)
                fault_cnt = fault_cnt + 1;
            lim = int'(limit_reg);
            if (lim == 0)
                lim = 1;
            if (lim > FRAMES)
                lim = FRAMES;
            if (resident_cnt < lim)
            begin
                found = 1'b0;
                for (int k = 0; k < FRAMES; k++)
                begin
                    if (!found && !frame_valid[k])
                    begin
                        found = 1'b1;
                        slot = k;
                    end
                end
                frame_valid[slot] = 1'b1;
                resident_cnt++;
            end
            else
            begin
                // lowest count, then largest age, then lowest frame
                found = 1'b0;
                best_uses = 0;
                best_age = '0;
                for (int k = 0; k < FRAMES; k++)
                begin
                    if (frame_valid[k])
                    begin
                        age = ref_tick - frame_stamp[k];
                        if (!found || int'(frame_uses[k]) < best_uses ||
                            (int'(frame_uses[k]) == best_uses && age > best_age))
                        begin
                            found = 1'b1;
                            slot = k;
                            best_uses = int'(frame_uses[k]);
                            best_age = age;
                        end
                    end
                end
                r.vic_valid = 1'b1;
                r.vic_page = frame_page[slot];
            end
            frame_page[slot] = page;
            frame_uses[slot] = 16'd1;
            frame_stamp[slot] = ref_tick;
        end
        ref_tick = ref_tick + 32'd1;
        r.slot = slot[SLOT_OUT_W-1:0];
        r.faults = fault_cnt;
        return r;
    endfunction

    // hold off new references until every outstanding result has come back
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // write the frame limit while the block is idle
    task automatic write_limit(input logic [CFG_W-1:0] value);
        drain_results();
        if ($urandom_range(0, 99) < 20)
            repeat ($urandom_range(1, 6)) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_reg = value;
    endtask

    // one reference beat; the expectation is either given or predicted
    task automatic send_ref(input logic [PAGE_ID_W-1:0] page, input int gap,
                            input bit use_given, input ref_result_t given);
        ref_result_t predicted;
        ref_result_t expected;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        page_id <= page;
        do
            @(posedge clk);
        while (busy);
        predicted = lfu_predict(page);
        if (use_given)
            expected = given;
        else
            expected = predicted;
        pending_results.insert(pending_results.size(), expected);
    endtask

    function automatic int pick_gap(input bit quiet);
        if (!quiet && $urandom_range(0, 99) < 20)
            return $urandom_range(1, 25);
        return 0;
    endfunction

    // result checker
    always @(posedge clk)
    begin : result_check
        ref_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with nothing expected:", $time,
                             " hit=%0b slot=%0d vv=%0b vp=%h ft=%0d",
                             hit, frame_slot, victim_valid, victim_page, fault_total);
            end
            else
            begin
                want = pending_results.pop_front();
                if (hit !== want.hit || frame_slot !== want.slot ||
                    victim_valid !== want.vic_valid || victim_page !== want.vic_page ||
                    fault_total !== want.faults)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch exp hit=%0b slot=%0d vv=%0b vp=%h ft=%0d",
                                 $time, want.hit, want.slot, want.vic_valid, want.vic_page,
                                 want.faults,
                                 " got hit=%0b slot=%0d vv=%0b vp=%h ft=%0d",
                                 hit, frame_slot, victim_valid, victim_page, fault_total);
                end
            end
        end
    end

    // watchdog: cycles with no beat on any port
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_n)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("tb_top: errors");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        ref_result_t          no_result;
        logic [PAGE_ID_W-1:0] pool [24];
        logic [CFG_W-1:0]     lim;
        int                   pool_n;
        int                   n_refs;
        int                   idx;
        int                   idx2;
        bit                   quiet;
        logic [PAGE_ID_W-1:0] page;

        no_result = '{1'b0, '0, 1'b0, '0, '0};
        for (int k = 0; k < FRAMES; k++)
        begin
            frame_valid[k] = 1'b0;
            frame_page[k]  = '0;
            frame_uses[k]  = '0;
            frame_stamp[k] = '0;
        end
        rst_n     = 1'b0;
        start     = 1'b0;
        page_id   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_limit(dir_rows[i].value[CFG_W-1:0]);
            else
                send_ref(dir_rows[i].value, pick_gap(1'b0), dir_rows[i].typed,
                         dir_rows[i].want);
        end

        // random phases: a limit per phase, references drawn mostly from a skewed working set
        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase)
                0: lim = 5'd16;
                1: lim = 5'd4;
                2: lim = 5'd1;
                3: lim = 5'd0;
                4: lim = 5'd31;
                5: lim = 5'd17;
                6: lim = 5'd2;
                7: lim = 5'd16;
                default: lim = CFG_W'($urandom_range(0, 31));
            endcase
            write_limit(lim);
            quiet = (phase == 7);
            pool_n = $urandom_range(2, 24);
            for (int k = 0; k < pool_n; k++)
            begin
                case ($urandom_range(0, 19))
                    0: pool[k] = '0;
                    1: pool[k] = '1;
                    default: pool[k] = PAGE_ID_W'($urandom);
                endcase
            end
            n_refs = $urandom_range(90, 115);
            for (int i = 0; i < n_refs; i++)
            begin
                // sender pauses until the block has returned everything
                if (phase == 4 && i == n_refs / 2)
                    drain_results();
                if ($urandom_range(0, 99) < 15)
                    page = PAGE_ID_W'($urandom);
                else
                begin
                    idx  = $urandom_range(0, pool_n - 1);
                    idx2 = $urandom_range(0, pool_n - 1);
                    page = pool[(idx < idx2) ? idx : idx2];
                end
                send_ref(page, pick_gap(quiet), 1'b0, no_result);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/lfu_pkg.sv
rtl/core/lfu_ctrl.sv
rtl/core/lfu_dpath.sv
rtl/core/lfu_page_replacement.sv
dv/tb_top.sv
